// ===== rtl/core/mtd_pkg.sv =====
// Shared types, constants and letter table for the Morse tone decoder.
package mtd_pkg;

  // Field widths
  localparam int LEVEL_W      = 10;
  localparam int TIME_BITS    = 32;
  localparam int SPACE_W      = 16;
  localparam int CHAR_W       = 7;
  localparam int MAX_ELEMENTS = 5;
  // heap-numbered tree node: root is 1, deepest node needs MAX_ELEMENTS+1 bits
  localparam int TREE_W       = MAX_ELEMENTS + 2;

  // Configuration channel
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 4'd0,
    REG_ON_THRESHOLD = 4'd1,
    REG_LETTER_SPACE = 4'd2,
    REG_WORD_SPACE   = 4'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [LEVEL_W-1:0] ON_THRESHOLD_RST = LEVEL_W'(700);
  localparam logic [SPACE_W-1:0] LETTER_SPACE_RST = SPACE_W'(184);
  localparam logic [SPACE_W-1:0] WORD_SPACE_RST   = SPACE_W'(369);

  // Event kinds
  localparam logic EV_LETTER = 1'b0;
  localparam logic EV_WORD   = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = CHAR_W'(8'h2A);
  localparam logic [CHAR_W-1:0] CHAR_NONE    = '0;

  localparam logic [TREE_W-1:0] TREE_ROOT = TREE_W'(1);

  // Letter table, entry i holds the letter of tree node i+2
  localparam int TABLE_LEN   = 63;
  localparam int TABLE_IDX_W = 6;
  localparam logic [0:TABLE_LEN-1][7:0] LETTER_TABLE =
    "ETIANMSURWDKGOHVF*L*PJBXCYZQ**54*3***2**+****16=/*****7***8*90*";

  typedef struct packed {
    logic               enable;
    logic [LEVEL_W-1:0] on_threshold;
    logic [SPACE_W-1:0] letter_space;
    logic [SPACE_W-1:0] word_space;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   level;
    logic [TIME_BITS-1:0] now_ms;
  } sample_t;

  // Letter of a tree node; overflowed, empty or off-table letters give '*'
  function automatic logic [CHAR_W-1:0] letter_of(logic [TREE_W-1:0] node,
                                                  logic too_long);
    logic [TREE_W-1:0] idx;
    logic [7:0]        ch;
    idx = node - TREE_W'(2);
    ch  = LETTER_TABLE[idx[TABLE_IDX_W-1:0]];
    if (too_long || node < TREE_W'(2) || idx >= TREE_W'(TABLE_LEN)) begin
      letter_of = CHAR_UNKNOWN;
    end else begin
      letter_of = ch[CHAR_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/mtd_if.sv =====
// Channel interfaces: sample input, event output and configuration writes.
interface mtd_in_if;
  logic                           valid;
  logic                           ready;
  logic [mtd_pkg::LEVEL_W-1:0]    level;
  logic [mtd_pkg::TIME_BITS-1:0]  now_ms;

  modport source (output valid, level, now_ms, input ready);
  modport sink   (input valid, level, now_ms, output ready);
endinterface

interface mtd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        event_kind;
  logic [mtd_pkg::CHAR_W-1:0]  character;

  modport source (output valid, event_kind, character, input ready);
  modport sink   (input valid, event_kind, character, output ready);
endinterface

interface mtd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mtd_pkg::CFG_IDX_W-1:0]   index;
  logic [mtd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mtd_cfg_regs.sv =====
// Configuration register file of the Morse tone decoder.
module mtd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  mtd_cfg_if.sink       cfg_chan,
  output mtd_pkg::cfg_t cfg
);
  import mtd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken
  assign cfg_chan.ready = 1'b1;

  // Register decode; indexes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_ENABLE:       cfg_nxt.enable       = cfg_chan.data[0];
        REG_ON_THRESHOLD: cfg_nxt.on_threshold = cfg_chan.data[LEVEL_W-1:0];
        REG_LETTER_SPACE: cfg_nxt.letter_space = cfg_chan.data[SPACE_W-1:0];
        REG_WORD_SPACE:   cfg_nxt.word_space   = cfg_chan.data[SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b0;
      cfg_r.on_threshold <= ON_THRESHOLD_RST;
      cfg_r.letter_space <= LETTER_SPACE_RST;
      cfg_r.word_space   <= WORD_SPACE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/mtd_in_stage.sv =====
// Input register stage: holds one accepted sample until decode takes it.
module mtd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  mtd_in_if.sink           in_chan,
  input  logic             s1_take,
  output logic             s1_valid,
  output mtd_pkg::sample_t s1_data
);
  import mtd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  sample_t data_r;
  logic    accept;

  // Accept when empty or when the held sample moves on this cycle
  assign in_chan.ready = !valid_r || s1_take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (s1_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r.level  <= in_chan.level;
      data_r.now_ms <= in_chan.now_ms;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

// ===== rtl/core/mtd_decode.sv =====
// Decoder state, tone/gap classification and result register.
module mtd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  mtd_pkg::cfg_t    cfg,
  input  logic             s1_valid,
  input  mtd_pkg::sample_t s1_data,
  output logic             s1_take,
  mtd_out_if.source        out_chan
);
  import mtd_pkg::*;

  // Decoder state
  logic                 tone_on_r,        tone_on_nxt;
  logic                 word_started_r,   word_started_nxt;
  logic                 letter_emitted_r, letter_emitted_nxt;
  logic [TIME_BITS-1:0] last_change_r,    last_change_nxt;
  logic [TREE_W-1:0]    tree_r,           tree_nxt;
  logic                 too_long_r,       too_long_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r;
  logic [CHAR_W-1:0]    out_char_r;

  logic                 out_free;
  logic                 step;
  logic                 tone_hi;
  logic                 tone_start;
  logic                 tone_end;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] interval;
  logic                 nz;
  logic                 ws_after;
  logic                 elem;
  logic                 gap;
  logic                 letter_ev;
  logic                 word_ev;
  logic                 dah;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_take  = out_free;
  assign step     = s1_valid && out_free && cfg.enable;

  // Classify the sample against the current state
  assign tone_hi    = s1_data.level > cfg.on_threshold;
  assign tone_start = tone_hi && !tone_on_r;
  assign tone_end   = !tone_hi && tone_on_r;
  assign diff       = s1_data.now_ms - last_change_r;

  always_comb begin
    interval = '0;
    if (tone_start) begin
      if (word_started_r) interval = diff;
    end else if (!tone_hi) begin
      interval = diff;
    end
  end

  assign nz        = interval != '0;
  assign ws_after  = word_started_r || tone_start;
  assign elem      = tone_end && nz;
  assign gap       = nz && !elem && ws_after;
  assign letter_ev = gap && !letter_emitted_r &&
                     (interval > TIME_BITS'(cfg.letter_space));
  assign word_ev   = gap && !letter_ev && (interval > TIME_BITS'(cfg.word_space));
  assign dah       = interval > TIME_BITS'(cfg.letter_space);

  // Next state
  always_comb begin
    tone_on_nxt        = tone_on_r;
    word_started_nxt   = word_started_r;
    letter_emitted_nxt = letter_emitted_r;
    last_change_nxt    = last_change_r;
    tree_nxt           = tree_r;
    too_long_nxt       = too_long_r;
    if (step) begin
      tone_on_nxt      = tone_hi;
      word_started_nxt = ws_after;
      if (tone_start || tone_end) last_change_nxt = s1_data.now_ms;
      // a tone end of nonzero length adds a dit or dah unless the tree is already full depth
      if (elem) begin
        if (tree_r[TREE_W-1:MAX_ELEMENTS] != '0) begin
          too_long_nxt = 1'b1;
        end else begin
          tree_nxt = {tree_r[TREE_W-2:0], dah};
        end
      end
      if (letter_ev) begin
        letter_emitted_nxt = 1'b1;
        tree_nxt           = TREE_ROOT;
        too_long_nxt       = 1'b0;
      end
      // word space clears the whole decoder
      if (word_ev) begin
        tone_on_nxt        = 1'b0;
        word_started_nxt   = 1'b0;
        letter_emitted_nxt = 1'b0;
        last_change_nxt    = '0;
        tree_nxt           = TREE_ROOT;
        too_long_nxt       = 1'b0;
      end
      // each new tone opens a new letter
      if (tone_start) letter_emitted_nxt = 1'b0;
    end
  end

  // Result valid: loaded whenever a sample moves through, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_valid && out_free) begin
      out_valid_nxt = step && (letter_ev || word_ev);
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_on_r        <= 1'b0;
      word_started_r   <= 1'b0;
      letter_emitted_r <= 1'b0;
      last_change_r    <= '0;
      tree_r           <= TREE_ROOT;
      too_long_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      tone_on_r        <= tone_on_nxt;
      word_started_r   <= word_started_nxt;
      letter_emitted_r <= letter_emitted_nxt;
      last_change_r    <= last_change_nxt;
      tree_r           <= tree_nxt;
      too_long_r       <= too_long_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (step && (letter_ev || word_ev)) begin
      out_kind_r <= word_ev ? EV_WORD : EV_LETTER;
      out_char_r <= letter_ev ? letter_of(tree_r, too_long_r) : CHAR_NONE;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.event_kind = out_kind_r;
  assign out_chan.character  = out_char_r;

  // Tree node never leaves the heap numbering
  a_tree_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tree_r != '0)
    else $error("tree node is zero");

  // Tone or emitted letter only exist inside a started word
  a_word_started: assert property (@(posedge clk) disable iff (!rst_n)
    (tone_on_r || letter_emitted_r) |-> word_started_r)
    else $error("tone or letter state outside a word");

  // A word space leaves the decoder empty
  a_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && word_ev) |=> (tree_r == TREE_ROOT && !tone_on_r && !word_started_r
                           && !too_long_r && out_valid_r))
    else $error("word space did not clear decoder");

  // A disabled block produces nothing
  a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_free && !cfg.enable) |=> !out_valid_r)
    else $error("result while disabled");

endmodule

// ===== rtl/core/morse_tone_decoder_core.sv =====
// An accepted sample passes the input register, then the result register on out_chan.
// Throughput: one sample per cycle unless back-pressure stalls; input register and
// result register each fill while the other side stalls, so in_chan.ready drops
// only on back-pressure. Configuration writes are registered and always ready.
// Reset (rst_n low, synchronous): registers return to their defaults, the
// decoder is empty and both channel stages hold no transaction.
module morse_tone_decoder_core (
  input  logic     clk,
  input  logic     rst_n,
  mtd_cfg_if.sink  cfg_chan,
  mtd_in_if.sink   in_chan,
  mtd_out_if.source out_chan
);
  import mtd_pkg::*;

  cfg_t    cfg;
  sample_t s1_data;
  logic    s1_valid;
  logic    s1_take;

  mtd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  mtd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  mtd_decode u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_take  (s1_take),
    .out_chan (out_chan)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the Morse tone decoder core: sample driver, event checker and decode predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtd_pkg::*;

  // One decoded event as it should leave the block
  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] ch;
  } tone_event_t;

  // Letters of the heap-numbered tree, entry i belongs to node i+2
  localparam logic [0:TABLE_LEN-1][7:0] CODE_TREE =
    "ETIANMSURWDKGOHVF*L*PJBXCYZQ**54*3***2**+****16=/*****7***8*90*";
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT = 20000;

  logic clk;
  logic rst_n;

  mtd_cfg_if cfg_chan ();
  mtd_in_if  in_chan ();
  mtd_out_if out_chan ();

  morse_tone_decoder_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Register copy held by the predictor
  logic               cfg_enable;
  logic [LEVEL_W-1:0] cfg_thr;
  logic [SPACE_W-1:0] cfg_letter_gap;
  logic [SPACE_W-1:0] cfg_word_gap;

  // Decoder state held by the predictor
  logic                 tone_on;
  logic                 word_started;
  logic                 letter_sent;
  logic                 too_long;
  logic [TIME_BITS-1:0] last_edge_ms;
  int unsigned          tree_node;

  sample_t     samples_q[$];
  tone_event_t tone_events[$];
  sample_t     next_sample;
  tone_event_t predicted;
  tone_event_t oldest;

  int          mismatch_cnt;
  bit          steady_mode;
  int          choke_reqs;
  int          choke_seen;
  int          hold_left;
  int          queued_items;
  logic [TIME_BITS-1:0] sim_ms;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_decoder();
    tone_on      = 1'b0;
    word_started = 1'b0;
    letter_sent  = 1'b0;
    too_long     = 1'b0;
    last_edge_ms = '0;
    tree_node    = 1;
  endfunction

  function automatic logic [CHAR_W-1:0] letter_at();
    if (too_long || tree_node < 2 || tree_node - 2 >= TABLE_LEN) return CHAR_UNKNOWN;
    return CODE_TREE[tree_node - 2][CHAR_W-1:0];
  endfunction

  // Advances the decoder by one sample; returns 1 when an event comes out
  function automatic bit decode_sample(input logic [LEVEL_W-1:0] lvl,
                                       input logic [TIME_BITS-1:0] now,
                                       output tone_event_t ev);
    logic [TIME_BITS-1:0] span;
    bit                   began;
    bit                   hit;
    span  = '0;
    began = 1'b0;
    hit   = 1'b0;
    ev    = '0;
    if (!cfg_enable) return 1'b0;

    if (lvl > cfg_thr) begin
      if (!tone_on) begin
        if (word_started) span = now - last_edge_ms;
        tone_on      = 1'b1;
        last_edge_ms = now;
        word_started = 1'b1;
        began        = 1'b1;
      end
    end else begin
      span = now - last_edge_ms;
      if (tone_on) begin
        tone_on      = 1'b0;
        last_edge_ms = now;
      end
    end

    if (span != 0 && !tone_on && last_edge_ms == now) begin
      // tone just ended: its length picks dit or dah
      if (tree_node >= (1 << MAX_ELEMENTS)) begin
        too_long = 1'b1;
      end else begin
        tree_node = tree_node * 2 + ((span > cfg_letter_gap) ? 1 : 0);
      end
    end else if (span != 0 && word_started) begin
      // off gap: letter space has priority, word space is checked otherwise
      if (!letter_sent && span > cfg_letter_gap) begin
        ev.kind     = EV_LETTER;
        ev.ch       = letter_at();
        hit         = 1'b1;
        letter_sent = 1'b1;
        tree_node   = 1;
        too_long    = 1'b0;
      end else if (span > cfg_word_gap) begin
        ev.kind = EV_WORD;
        ev.ch   = CHAR_NONE;
        hit     = 1'b1;
        clear_decoder();
      end
    end

    if (began) letter_sent = 1'b0;
    return hit;
  endfunction

  // ---------------------------------------------------------------- sample driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      // transaction taken at this edge: predict its event
      if (in_chan.valid && in_chan.ready) begin
        if (decode_sample(in_chan.level, in_chan.now_ms, predicted)) begin
          tone_events.push_back(predicted);
        end
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (samples_q.size() != 0 && (steady_mode || $urandom_range(99) >= 16)) begin
          next_sample = samples_q.pop_front();
          in_chan.valid  <= 1'b1;
          in_chan.level  <= next_sample.level;
          in_chan.now_ms <= next_sample.now_ms;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- event sink

  // random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left      <= 0;
      choke_seen     <= 0;
    end else begin
      if (choke_seen != choke_reqs) begin
        hold_left  <= HOLD_CYCLES;
        choke_seen <= choke_reqs;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_chan.ready <= (hold_left == 0) && (choke_seen == choke_reqs) &&
                        (steady_mode || $urandom_range(99) >= 16);
    end
  end

  // compare every event transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (tone_events.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("[%0t] unexpected event: kind %0b char 0x%02h", $realtime,
                   out_chan.event_kind, out_chan.character);
        end
      end else begin
        oldest = tone_events.pop_front();
        if (out_chan.event_kind !== oldest.kind || out_chan.character !== oldest.ch) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("[%0t] event mismatch: expected kind %0b char 0x%02h, got kind %0b char 0x%02h",
                     $realtime, oldest.kind, oldest.ch, out_chan.event_kind,
                     out_chan.character);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic add_sample(input logic [LEVEL_W-1:0] lvl, input logic [TIME_BITS-1:0] t);
    sample_t s;
    s.level  = lvl;
    s.now_ms = t;
    samples_q.push_back(s);
    queued_items++;
  endtask

  function automatic logic [LEVEL_W-1:0] tone_level();
    if (cfg_thr == {LEVEL_W{1'b1}}) return cfg_thr;
    return LEVEL_W'($urandom_range(1023, cfg_thr + 1));
  endfunction

  function automatic logic [LEVEL_W-1:0] quiet_level();
    return LEVEL_W'($urandom_range(cfg_thr, 0));
  endfunction

  function automatic int unsigned dit_len();
    if ($urandom_range(15) == 0) return 0;
    return $urandom_range(cfg_letter_gap == 0 ? 1 : cfg_letter_gap, 1);
  endfunction

  function automatic int unsigned dah_len();
    return cfg_letter_gap + $urandom_range(cfg_letter_gap / 2 + 20, 1);
  endfunction

  // key down for len ms, sometimes with a repeated on sample inside
  task automatic hold_tone(input int unsigned len);
    add_sample(tone_level(), sim_ms);
    if (len > 1 && $urandom_range(3) == 0) add_sample(tone_level(), sim_ms + $urandom_range(len - 1, 1));
    sim_ms += len;
    add_sample(quiet_level(), sim_ms);
  endtask

  // key up for len ms with pts off samples spread over it, the last at its end
  task automatic hold_silence(input int unsigned len, input int unsigned pts);
    for (int i = 1; i <= pts; i++) begin
      add_sample(quiet_level(), sim_ms + (len * i) / pts);
    end
    sim_ms += len;
  endtask

  task automatic send_letter();
    int unsigned n_el;
    n_el = ($urandom_range(7) == 0) ? $urandom_range(MAX_ELEMENTS + 2, MAX_ELEMENTS + 1)
                                    : $urandom_range(MAX_ELEMENTS, 1);
    for (int i = 0; i < n_el; i++) begin
      if (i != 0) hold_silence(dit_len(), $urandom_range(1, 0));
      hold_tone($urandom_range(1) ? dit_len() : dah_len());
    end
  endtask

  // letter space, word space, or just an element gap
  task automatic after_letter();
    int unsigned sel;
    int unsigned lsp;
    int unsigned wsp;
    sel = $urandom_range(99);
    lsp = cfg_letter_gap;
    wsp = cfg_word_gap;
    if (sel < 55) begin
      hold_silence(lsp + $urandom_range(lsp / 2 + 20, 1), $urandom_range(2, 0));
    end else if (sel < 90) begin
      hold_silence((lsp > wsp ? lsp : wsp) + $urandom_range(300, 1), $urandom_range(3, 0));
    end else begin
      hold_silence(dit_len(), $urandom_range(1, 0));
    end
  endtask

  task automatic add_noise();
    if ($urandom_range(3) == 0) begin
      sim_ms = $urandom();
    end else begin
      sim_ms += $urandom_range(cfg_letter_gap * 3 + 10, 0);
    end
    add_sample(LEVEL_W'($urandom()), sim_ms);
  endtask

  task automatic run_traffic(input int n);
    int first;
    first = queued_items;
    while (queued_items - first < n) begin
      if ($urandom_range(99) < 82) begin
        send_letter();
        after_letter();
      end else begin
        add_noise();
      end
    end
  endtask

  // wait until every sample is taken and every event has come back, then a quiet stretch
  task automatic settle();
    int waited;
    int quiet;
    waited = 0;
    quiet  = 0;
    while (quiet < 8 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
      if (samples_q.size() != 0 || in_chan.valid || tone_events.size() != 0) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    case (idx)
      REG_ENABLE:       cfg_enable     = val[0];
      REG_ON_THRESHOLD: cfg_thr        = val[LEVEL_W-1:0];
      REG_LETTER_SPACE: cfg_letter_gap = val;
      REG_WORD_SPACE:   cfg_word_gap   = val;
      default: ;
    endcase
  endtask

  // unused upper data bits carry junk to check masking
  task automatic apply_settings(input logic en, input logic [LEVEL_W-1:0] thr,
                                input logic [SPACE_W-1:0] lsp,
                                input logic [SPACE_W-1:0] wsp);
    write_reg(REG_ENABLE, {15'($urandom()), en});
    write_reg(REG_ON_THRESHOLD, {6'($urandom()), thr});
    write_reg(REG_LETTER_SPACE, lsp);
    write_reg(REG_WORD_SPACE, wsp);
  endtask

  // ---------------------------------------------------------------- test sequence

  initial begin
    logic [SPACE_W-1:0] mid_gap;
    rst_n          = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = REG_ENABLE;
    cfg_chan.data  = '0;
    in_chan.valid  = 1'b0;
    in_chan.level  = '0;
    in_chan.now_ms = '0;
    out_chan.ready = 1'b0;
    steady_mode    = 1'b0;
    choke_reqs     = 0;
    mismatch_cnt   = 0;
    queued_items   = 0;
    sim_ms         = '0;
    cfg_enable     = 1'b0;
    cfg_thr        = ON_THRESHOLD_RST;
    cfg_letter_gap = LETTER_SPACE_RST;
    cfg_word_gap   = WORD_SPACE_RST;
    clear_decoder();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset: sample is dropped
    add_sample(10'd1023, 32'd0);
    settle();
    write_reg(REG_ENABLE, 16'd1);

    // single dit, threshold boundary, letter then word on off samples
    add_sample(10'd701, 32'd1000);
    add_sample(10'd700, 32'd1060);
    add_sample(10'd0, 32'd1300);
    add_sample(10'd0, 32'd1500);
    // zero-length tone, then empty letter
    add_sample(10'd1023, 32'd2000);
    add_sample(10'd0, 32'd2000);
    add_sample(10'd0, 32'd2300);
    // word space seen at a tone start, then a fresh tone
    add_sample(10'd1023, 32'd2700);
    add_sample(10'd1023, 32'd2710);
    add_sample(10'd0, 32'd2960);
    // zero gap, then letter emitted at the next tone start
    add_sample(10'd800, 32'd2960);
    add_sample(10'd0, 32'd3010);
    add_sample(10'd1023, 32'd3300);
    // too many elements across the time wrap, then word at max time
    add_sample(10'd0, 32'hFFFF_FF00);
    for (int k = 1; k <= 5; k++) begin
      add_sample(10'd1023, 32'hFFFF_FF00 + 100 * k);
      add_sample(10'd0, 32'hFFFF_FF00 + 100 * k + 50);
    end
    add_sample(10'd0, 32'hFFFF_FF00 + 850);
    add_sample(10'd0, 32'hFFFF_FFFF);
    settle();

    // default timing; receiver holds off while the queue keeps coming
    apply_settings(1'b1, 10'd700, 16'd184, 16'd369);
    sim_ms = 32'd10000;
    run_traffic(110);
    @(posedge clk);
    choke_reqs <= choke_reqs + 1;
    settle();

    // low extremes: every level above zero is on, every gap is a space
    apply_settings(1'b1, 10'd0, 16'd0, 16'd0);
    run_traffic(40);
    settle();

    // high extremes: no sample ever counts as tone
    apply_settings(1'b1, 10'd1023, 16'hFFFF, 16'hFFFF);
    run_traffic(20);
    settle();

    // disabled: samples are ignored
    apply_settings(1'b0, LEVEL_W'($urandom()), 16'd100, 16'd200);
    run_traffic(15);
    settle();

    // longest spaces across the time wrap
    apply_settings(1'b1, LEVEL_W'($urandom_range(900, 100)), 16'hFFFF, 16'hFFFF);
    sim_ms = 32'hFFFC_0000;
    run_traffic(60);
    settle();

    // mid-range timing with no stalls at all
    mid_gap = SPACE_W'($urandom_range(300, 20));
    steady_mode <= 1'b1;
    apply_settings(1'b1, LEVEL_W'($urandom_range(1000, 0)), mid_gap,
                   SPACE_W'(mid_gap * 2 + SPACE_W'($urandom_range(60, 0))));
    run_traffic(120);
    settle();
    steady_mode <= 1'b0;

    // arbitrary timing, word space possibly below letter space
    apply_settings(1'b1, LEVEL_W'($urandom()), SPACE_W'($urandom_range(400, 0)),
                   SPACE_W'($urandom_range(600, 0)));
    sim_ms = $urandom();
    run_traffic(60);
    settle();

    mismatch_cnt += tone_events.size();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
